// ----- rtl/core/enhanced_clock_page_replacement_defines.svh -----
`ifndef ENHANCED_CLOCK_PAGE_REPLACEMENT_DEFINES_SVH
`define ENHANCED_CLOCK_PAGE_REPLACEMENT_DEFINES_SVH

// Check a condition at every edge outside reset.
`define ECPR_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define ECPR_ASSERT_IMPL(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define ECPR_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/ecpr_pkg.sv -----
package ecpr_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 6;

  localparam int PAGE_IN_W  = 6;
  localparam int FRAME_IX_W = 3;
  localparam int FAULT_W    = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  typedef struct packed {
    logic scan;
    logic pass_b;
    logic wr;
  } cell_ctl_t;

  typedef struct packed {
    logic match;
    logic victim;
    logic dirty_sel;
  } cell_stat_t;

endpackage

// ----- rtl/core/ecpr_cell.sv -----
module ecpr_cell #(
  parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF,
  parameter bit IS_HEAD   = 1'b0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ecpr_pkg::cell_ctl_t   ctl,
  input  logic [PAGE_BITS-1:0]  key,
  input  logic                  hit_sel,
  input  logic                  fill_sel,
  input  logic                  tok_prev,
  output logic                  tok,
  output ecpr_pkg::cell_stat_t  stat,
  output logic [PAGE_BITS-1:0]  page_sel
);

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r, ref_r, mod_r, tok_r;
  logic                 victim, load;

  assign victim = tok_r & ctl.scan & ~ref_r & (ctl.pass_b ? mod_r : ~mod_r);
  assign load   = fill_sel | victim;

  assign tok            = tok_r;
  assign stat.match     = valid_r & (page_r == key);
  assign stat.victim    = victim;
  assign stat.dirty_sel = tok_r & mod_r;
  assign page_sel       = tok_r ? page_r : '0;

  always_ff @(posedge clk) begin
    if (load) begin
      page_r <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ref_r   <= 1'b0;
      mod_r   <= 1'b0;
      tok_r   <= IS_HEAD;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        ref_r   <= 1'b1;
        mod_r   <= ctl.wr;
      end else if (hit_sel) begin
        ref_r <= 1'b1;
        mod_r <= mod_r | ctl.wr;
      end else if (ctl.scan && ctl.pass_b && tok_r) begin
        ref_r <= 1'b0;
      end
      if (ctl.scan) begin
        tok_r <= tok_prev;
      end
    end
  end

endmodule

// ----- rtl/core/enhanced_clock_page_replacement.sv -----
// Channel  Dir  Ports                         Beat contents
// in       in   in_tvalid/in_tready/in_tdata  one page access
// out      out  out_tvalid/out_tready/out_tdata  one lookup result
// One access at a time. Hit or fill: LOOK registers the result once the output register
// is free. Fault: SCAN registers it after the hand token visits n frames (1 to 4*FRAMES),
// as the token ring advances one cell per cycle while the output register is free.
// Synchronous active-low reset clears valid, ref and modify bits, counters and hand.
// A full output register holds the final step until out_tready frees it.
`include "enhanced_clock_page_replacement_defines.svh"

module enhanced_clock_page_replacement #(
  parameter int FRAMES    = ecpr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] page_number, [6] is_write, [7] zero
  input  logic [ecpr_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] hit, [3:1] frame_index, [4] evicted_valid, [10:5] evicted_page,
  // [11] evicted_dirty, [27:12] fault_total, [31:28] zero
  output logic [ecpr_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int HW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FW = $clog2(FRAMES + 1);
  localparam int PW = ecpr_pkg::PAGE_IN_W;
  localparam int XW = ecpr_pkg::FRAME_IX_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;

  logic [1:0]                   state_r, state_nxt;
  logic [PAGE_BITS-1:0]         key_r;
  logic                         wr_r;
  logic [FW-1:0]                fill_r, fill_nxt;
  logic [HW-1:0]                hand_r, hand_nxt;
  logic [HW-1:0]                pos_r, pos_nxt;
  logic                         passb_r, passb_nxt;
  logic [ecpr_pkg::FAULT_W-1:0] fault_r, fault_nxt;

  logic                         out_tvalid_r;
  logic                         o_hit_r, o_ev_r, o_dirty_r;
  logic [HW-1:0]                o_idx_r;
  logic [PAGE_BITS-1:0]         o_page_r;

  ecpr_pkg::cell_ctl_t          ctl;
  ecpr_pkg::cell_stat_t         stat [FRAMES];
  logic [PAGE_BITS-1:0]         psel [FRAMES];
  logic [FRAMES-1:0]            tok_vec, match_vec, victim_vec, hit_sel, fill_sel;
  logic [FRAMES-1:0]            dirty_vec;
  logic [PAGE_BITS-1:0]         ev_page;
  logic [HW-1:0]                hit_idx;
  logic                         out_free, look_go, hit_go, fill_go, fault_go, found;
  logic                         produce, p_hit, p_ev, p_dirty;
  logic [HW-1:0]                p_idx;
  logic [PAGE_BITS+PW-1:0]      key_ext;
  logic [PAGE_BITS+PW-1:0]      page_out_ext;
  logic [HW+XW-1:0]             idx_out_ext;

  assign in_tready = (state_r == ST_IDLE);
  assign out_free  = ~out_tvalid_r | out_tready;
  assign key_ext   = {{PAGE_BITS{1'b0}}, in_tdata[PW-1:0]};

  assign look_go  = (state_r == ST_LOOK) && out_free;
  assign hit_go   = look_go && (|match_vec);
  assign fill_go  = look_go && !(|match_vec) && (fill_r < FW'(FRAMES));
  assign fault_go = look_go && !(|match_vec) && (fill_r >= FW'(FRAMES));

  assign ctl.scan   = (state_r == ST_SCAN) && out_free;
  assign ctl.pass_b = passb_r;
  assign ctl.wr     = wr_r;

  always_comb begin
    hit_idx = '0;
    ev_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (match_vec[i]) begin
        hit_idx = hit_idx | HW'(i);
      end
      ev_page = ev_page | psel[i];
    end
  end

  assign found = |victim_vec;

  genvar g;
  generate
    for (g = 0; g < FRAMES; g++) begin : g_cell
      assign hit_sel[g]    = hit_go & match_vec[g];
      assign fill_sel[g]   = fill_go & (fill_r[HW-1:0] == HW'(g));
      assign match_vec[g]  = stat[g].match;
      assign victim_vec[g] = stat[g].victim;
      assign dirty_vec[g]  = stat[g].dirty_sel;

      ecpr_cell #(
        .PAGE_BITS (PAGE_BITS),
        .IS_HEAD   (g == 0)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .key      (key_r),
        .hit_sel  (hit_sel[g]),
        .fill_sel (fill_sel[g]),
        .tok_prev (tok_vec[(g + FRAMES - 1) % FRAMES]),
        .tok      (tok_vec[g]),
        .stat     (stat[g]),
        .page_sel (psel[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    hand_nxt  = hand_r;
    pos_nxt   = pos_r;
    passb_nxt = passb_r;
    fault_nxt = fault_r;
    produce   = 1'b0;
    p_hit     = 1'b0;
    p_ev      = 1'b0;
    p_dirty   = 1'b0;
    p_idx     = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (hit_go) begin
          produce   = 1'b1;
          p_hit     = 1'b1;
          p_idx     = hit_idx;
          state_nxt = ST_IDLE;
        end else if (fill_go) begin
          produce   = 1'b1;
          p_idx     = fill_r[HW-1:0];
          fill_nxt  = fill_r + FW'(1);
          state_nxt = ST_IDLE;
        end else if (fault_go) begin
          if (fault_r != ecpr_pkg::FAULT_MAX) begin
            fault_nxt = fault_r + {{(ecpr_pkg::FAULT_W-1){1'b0}}, 1'b1};
          end
          pos_nxt   = '0;
          passb_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ctl.scan) begin
          hand_nxt = (hand_r == HW'(FRAMES - 1)) ? '0 : hand_r + HW'(1);
          if (found) begin
            produce   = 1'b1;
            p_ev      = 1'b1;
            p_dirty   = |dirty_vec;
            p_idx     = hand_r;
            state_nxt = ST_IDLE;
          end else if (pos_r == HW'(FRAMES - 1)) begin
            pos_nxt   = '0;
            passb_nxt = ~passb_r;
          end else begin
            pos_nxt = pos_r + HW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fill_r       <= '0;
      hand_r       <= '0;
      pos_r        <= '0;
      passb_r      <= 1'b0;
      fault_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      hand_r  <= hand_nxt;
      pos_r   <= pos_nxt;
      passb_r <= passb_nxt;
      fault_r <= fault_nxt;
      if (produce) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r <= key_ext[PAGE_BITS-1:0];
      wr_r  <= in_tdata[PW];
    end
    if (produce) begin
      o_hit_r   <= p_hit;
      o_idx_r   <= p_idx;
      o_ev_r    <= p_ev;
      o_page_r  <= p_ev ? ev_page : '0;
      o_dirty_r <= p_dirty;
    end
  end

  assign idx_out_ext  = {{XW{1'b0}}, o_idx_r};
  assign page_out_ext = {{PW{1'b0}}, o_page_r};

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, fault_r, o_dirty_r, page_out_ext[PW-1:0], o_ev_r,
                       idx_out_ext[XW-1:0], o_hit_r};

  `ECPR_ASSERT_ALWAYS(a_tok_onehot, $onehot(tok_vec), "hand token not one-hot")
  `ECPR_ASSERT_ALWAYS(a_tok_hand, tok_vec[hand_r], "hand token and hand index disagree")
  `ECPR_ASSERT_ALWAYS(a_match_unique, $onehot0(match_vec), "page resident in two frames")
  `ECPR_ASSERT_NEXT(a_fault_full, fault_go, fill_r == FW'(FRAMES), "fault before frames full")

endmodule
